// ===== src/vector3_normalize_unit_macros.svh =====
// Assertion macros shared by the vector3_normalize_unit RTL.
// No dependencies; each user supplies clk and rst in scope.
`ifndef VECTOR3_NORMALIZE_UNIT_MACROS_SVH
`define VECTOR3_NORMALIZE_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define VNU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vnu assertion failed");

// Next-cycle implication, disabled in reset.
`define VNU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vnu assertion failed");

`endif

// ===== src/vnu_pkg.sv =====
// Types and constants for the vector normalize pipeline.
// No dependencies.
package vnu_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam logic [30:0] UNIT_ONE = 31'h4000_0000;

  // Component magnitudes and signs that ride along the root chain.
  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] a;
  } vec_tag_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
    vec_tag_t    tag;
  } sqrt_word_t;

  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][30:0] num;
    logic [2:0][30:0] quo;
    logic [31:0]      len;
    logic             zero;
    logic [2:0]       neg;
  } div_word_t;

  // Pipeline control handed to every cell.
  typedef struct packed {
    logic en;
    logic valid;
  } cell_ctl_t;

endpackage

// ===== src/vnu_in_if.sv =====
// Input channel: one vector per beat.
// Depends on nothing.
interface vnu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_in;
  logic [31:0] y_in;
  logic [31:0] z_in;

  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

// ===== src/vnu_out_if.sv =====
// Output channel: unit vector, length and zero flag per beat.
// Depends on nothing.
interface vnu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_unit;
  logic [31:0] y_unit;
  logic [31:0] z_unit;
  logic [31:0] magnitude;
  logic        zero_vector;

  modport source (output valid, x_unit, y_unit, z_unit, magnitude, zero_vector,
                  input ready);
  modport sink   (input valid, x_unit, y_unit, z_unit, magnitude, zero_vector,
                  output ready);
endinterface

// ===== src/vector3_normalize_unit.sv =====
// Pipeline: abs, square, sum, 32 root cells, numerator, 31 divide cells, output.
// Throughput one vector per cycle; the whole chain advances together and holds
// only while the output register is full and not taken.
// Synchronous active-high reset clears every valid bit; payload is not reset.
// Depends on vnu_pkg, vnu_in_if, vnu_out_if, vnu_sqrt_cell, vnu_div_cell.
`include "vector3_normalize_unit_macros.svh"
module vector3_normalize_unit (
  input  logic      clk,
  input  logic      rst,
  vnu_in_if.sink    vec_in,
  vnu_out_if.source vec_out
);

  logic en;
  assign en = !vec_out.valid || vec_out.ready;
  assign vec_in.ready = en;

  // abs stage
  logic              v1;
  vnu_pkg::vec_tag_t tag1;
  logic [2:0][31:0]  comp;
  vnu_pkg::vec_tag_t tag1_next;

  assign comp = {vec_in.z_in, vec_in.y_in, vec_in.x_in};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tag1_next.neg[k] = comp[k][31];
      tag1_next.a[k]   = comp[k][31] ? (32'd0 - comp[k]) : comp[k];
    end
    tag1_next.zero = (comp == '0);
  end

  // square and sum stages
  logic              v2, v3;
  vnu_pkg::vec_tag_t tag2, tag3;
  logic [2:0][63:0]  sq;
  logic [63:0]       sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= vec_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1 <= tag1_next;
      tag2 <= tag1;
      tag3 <= tag2;
      for (int k = 0; k < 3; k++) begin
        sq[k] <= 64'(tag1.a[k]) * 64'(tag1.a[k]);
      end
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

  // square root chain
  logic                [vnu_pkg::SQRT_STEPS:0] sv;
  vnu_pkg::sqrt_word_t [vnu_pkg::SQRT_STEPS:0] sw;

  assign sv[0]       = v3;
  assign sw[0].rem   = '0;
  assign sw[0].root  = '0;
  assign sw[0].rad   = sum;
  assign sw[0].tag   = tag3;

  for (genvar i = 0; i < vnu_pkg::SQRT_STEPS; i++) begin : g_sqrt
    vnu_pkg::cell_ctl_t ctl;
    assign ctl.en    = en;
    assign ctl.valid = sv[i];
    vnu_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .din   (sw[i]),
      .valid (sv[i+1]),
      .dout  (sw[i+1])
    );
  end

  // numerator stage: (a << 30) + len/2
  vnu_pkg::sqrt_word_t sq_out;
  logic                v4;
  vnu_pkg::div_word_t  dw0;
  logic [2:0][61:0]    numer;

  assign sq_out = sw[vnu_pkg::SQRT_STEPS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      numer[k] = {sq_out.tag.a[k], 30'd0} + 62'(sq_out.root[31:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= sv[vnu_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dw0.rem[k] <= {1'b0, numer[k][61:31]};
        dw0.num[k] <= numer[k][30:0];
        dw0.quo[k] <= '0;
      end
      dw0.len  <= sq_out.root;
      dw0.zero <= sq_out.tag.zero;
      dw0.neg  <= sq_out.tag.neg;
    end
  end

  // divide chain
  logic               [vnu_pkg::DIV_STEPS:0] dv;
  vnu_pkg::div_word_t [vnu_pkg::DIV_STEPS:0] dw;

  assign dv[0] = v4;
  assign dw[0] = dw0;

  for (genvar i = 0; i < vnu_pkg::DIV_STEPS; i++) begin : g_div
    vnu_pkg::cell_ctl_t ctl;
    assign ctl.en    = en;
    assign ctl.valid = dv[i];
    vnu_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .din   (dw[i]),
      .valid (dv[i+1]),
      .dout  (dw[i+1])
    );
  end

  // clamp, sign and output register
  vnu_pkg::div_word_t dq;
  logic [2:0][31:0]   unit_next;

  assign dq = dw[vnu_pkg::DIV_STEPS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dq.zero) begin
        unit_next[k] = '0;
      end else if (dq.quo[k] > vnu_pkg::UNIT_ONE) begin
        unit_next[k] = dq.neg[k] ? (32'd0 - {1'b0, vnu_pkg::UNIT_ONE})
                                 : {1'b0, vnu_pkg::UNIT_ONE};
      end else begin
        unit_next[k] = dq.neg[k] ? (32'd0 - {1'b0, dq.quo[k]}) : {1'b0, dq.quo[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_out.valid <= 1'b0;
    end else if (en) begin
      vec_out.valid <= dv[vnu_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_out.x_unit      <= unit_next[0];
      vec_out.y_unit      <= unit_next[1];
      vec_out.z_unit      <= unit_next[2];
      vec_out.magnitude   <= dq.zero ? 32'd0 : dq.len;
      vec_out.zero_vector <= dq.zero;
    end
  end

  `VNU_ASSERT_IMPL(a_zero_out, vec_out.valid && vec_out.zero_vector, vec_out.magnitude == 32'd0 && vec_out.x_unit == 32'd0 && vec_out.y_unit == 32'd0 && vec_out.z_unit == 32'd0)
  `VNU_ASSERT_IMPL(a_len_nonzero, vec_out.valid && !vec_out.zero_vector, vec_out.magnitude != 32'd0)
  `VNU_ASSERT_IMPL(a_unit_range, vec_out.valid, $signed(vec_out.x_unit) <= 32'sh4000_0000 && $signed(vec_out.x_unit) >= -32'sh4000_0000)
  `VNU_ASSERT_NEXT(a_stall_hold, vec_out.valid && !vec_out.ready, vec_out.valid && $stable(vec_out.magnitude))

endmodule

// ===== src/vnu_sqrt_cell.sv =====
// One digit step of the restoring integer square root.
// Depends on vnu_pkg.
module vnu_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  vnu_pkg::cell_ctl_t  ctl,
  input  vnu_pkg::sqrt_word_t din,
  output logic                valid,
  output vnu_pkg::sqrt_word_t dout
);

  logic [34:0]         rem2;
  logic [34:0]         trial;
  vnu_pkg::sqrt_word_t word_next;

  always_comb begin
    rem2  = {din.rem[32:0], din.rad[63:62]};
    trial = {1'b0, din.root, 2'b01};
    word_next     = din;
    word_next.rad = {din.rad[61:0], 2'b00};
    if (rem2 >= trial) begin
      word_next.rem  = rem2 - trial;
      word_next.root = {din.root[30:0], 1'b1};
    end else begin
      word_next.rem  = rem2;
      word_next.root = {din.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.en) begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      dout <= word_next;
    end
  end

endmodule

// ===== src/vnu_div_cell.sv =====
// One quotient bit of the restoring divide, for all three components.
// Depends on vnu_pkg.
module vnu_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  vnu_pkg::cell_ctl_t ctl,
  input  vnu_pkg::div_word_t din,
  output logic               valid,
  output vnu_pkg::div_word_t dout
);

  logic [2:0][32:0]   rem2;
  vnu_pkg::div_word_t word_next;

  always_comb begin
    word_next = din;
    for (int k = 0; k < 3; k++) begin
      rem2[k] = {din.rem[k], din.num[k][30]};
      word_next.num[k] = {din.num[k][29:0], 1'b0};
      if (rem2[k] >= {1'b0, din.len}) begin
        word_next.rem[k] = 32'(rem2[k] - {1'b0, din.len});
        word_next.quo[k] = {din.quo[k][29:0], 1'b1};
      end else begin
        word_next.rem[k] = rem2[k][31:0];
        word_next.quo[k] = {din.quo[k][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.en) begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      dout <= word_next;
    end
  end

endmodule
